// ===== hw/rtl/bsp_pkg.sv =====
// Shared types and constants for the billboard sprite projection pipeline.
// No dependencies; imported by bsp_front, bsp_mid, bsp_back and the top level.
`default_nettype none

package bsp_pkg;

    // Register indexes of the configuration port
    typedef enum logic [2:0] {
        REG_VIEWER_X  = 3'd0,
        REG_VIEWER_Y  = 3'd1,
        REG_DIR_X     = 3'd2,
        REG_DIR_Y     = 3'd3,
        REG_PLANE_X   = 3'd4,
        REG_PLANE_Y   = 3'd5,
        REG_SCR_W     = 3'd6,
        REG_SCR_H     = 3'd7
    } t_cfg_reg;

    localparam int CFG_DATA_W = 24;
    localparam int POS_W      = 24;
    localparam int DIR_W      = 16;
    localparam int PIX_W      = 13;
    localparam logic [PIX_W-1:0] PIX_MAX = 13'd4096;

    localparam int DET_EPS    = 256;
    localparam int FRAC_SH    = 14;

    // divider shapes: camera-space pass and screen pass
    localparam int DEN_W      = 32;
    localparam int NUM1_W     = 55;
    localparam int Q1_W       = 32;
    localparam int NUM2_W     = 45;
    localparam int Q2_W       = 16;

    typedef struct packed {
        logic        [POS_W-1:0] viewer_x;
        logic        [POS_W-1:0] viewer_y;
        logic signed [DIR_W-1:0] dir_x;
        logic signed [DIR_W-1:0] dir_y;
        logic signed [DIR_W-1:0] plane_x;
        logic signed [DIR_W-1:0] plane_y;
        logic        [PIX_W-1:0] w;
        logic        [PIX_W-1:0] h;
    } t_cfg;

    typedef struct packed {
        logic sx;
        logic sdp;
        logic det_ok;
    } t_div1_tag;

    typedef struct packed {
        logic signed [31:0] cx;
        logic        [30:0] dp;
        logic               vis;
        logic               col_neg;
    } t_mid_tag;

endpackage

`default_nettype wire

// ===== hw/rtl/bsp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, shared denominator.
// Flags quotients that do not fit in Q_W bits. Uses no package.
`default_nettype none

module bsp_div #(
    parameter int LANES = 2,
    parameter int NUM_W = 55,
    parameter int DEN_W = 32,
    parameter int Q_W   = 32,
    parameter int TAG_W = 3
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [LANES-1:0][NUM_W-1:0]   i_num,
    input  logic [DEN_W-1:0]              i_den,
    input  logic [TAG_W-1:0]              i_tag,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [LANES-1:0][Q_W-1:0]     o_quo,
    output logic [LANES-1:0]              o_ovf,
    output logic [TAG_W-1:0]              o_tag
);

    localparam int HI_W  = NUM_W - Q_W;
    localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

    logic [Q_W:0]   r_v;
    logic [Q_W:0]   v_in;
    logic [Q_W+1:0] en;

    logic [LANES-1:0][DEN_W-1:0] r_rem [0:Q_W];
    logic [LANES-1:0][Q_W-1:0]   r_lo  [0:Q_W];
    logic [LANES-1:0][Q_W-1:0]   r_q   [0:Q_W];
    logic [LANES-1:0]            r_ovf [0:Q_W];
    logic [DEN_W-1:0]            r_den [0:Q_W];
    logic [TAG_W-1:0]            r_tag [0:Q_W];

    logic [LANES-1:0][DEN_W-1:0] n_rem0;
    logic [LANES-1:0]            n_ovf0;

    assign en[Q_W+1] = i_ready;
    assign v_in      = {r_v[Q_W-1:0], i_valid};
    assign o_ready   = en[0];

    genvar k;
    for (k = 0; k <= Q_W; k++) begin : g_en
        assign en[k] = !r_v[k] || en[k+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int s = 0; s <= Q_W; s++) begin
                if (en[s]) begin
                    r_v[s] <= v_in[s];
                end
            end
        end
    end

    // overflow test and starting remainder from the high numerator bits
    always_comb begin
        logic [HI_W-1:0] v_hi;
        n_rem0 = '0;
        n_ovf0 = '0;
        for (int l = 0; l < LANES; l++) begin
            v_hi      = i_num[l][NUM_W-1:Q_W];
            n_ovf0[l] = CMP_W'(v_hi) >= CMP_W'(i_den);
            n_rem0[l] = DEN_W'(v_hi);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_rem[0] <= n_rem0;
            r_ovf[0] <= n_ovf0;
            r_q[0]   <= '0;
            r_den[0] <= i_den;
            r_tag[0] <= i_tag;
            for (int l = 0; l < LANES; l++) begin
                r_lo[0][l] <= i_num[l][Q_W-1:0];
            end
        end
    end

    for (k = 1; k <= Q_W; k++) begin : g_stage
        logic [LANES-1:0][DEN_W-1:0] n_rem;
        logic [LANES-1:0]            n_bit;

        always_comb begin
            logic [DEN_W:0] v_t;
            n_rem = '0;
            n_bit = '0;
            for (int l = 0; l < LANES; l++) begin
                v_t = {r_rem[k-1][l], r_lo[k-1][l][Q_W-1]};
                if (v_t >= {1'b0, r_den[k-1]}) begin
                    n_bit[l] = 1'b1;
                    n_rem[l] = DEN_W'(v_t - {1'b0, r_den[k-1]});
                end else begin
                    n_rem[l] = v_t[DEN_W-1:0];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (en[k]) begin
                r_rem[k] <= n_rem;
                r_ovf[k] <= r_ovf[k-1];
                r_den[k] <= r_den[k-1];
                r_tag[k] <= r_tag[k-1];
                for (int l = 0; l < LANES; l++) begin
                    r_lo[k][l] <= {r_lo[k-1][l][Q_W-2:0], 1'b0};
                    r_q[k][l]  <= {r_q[k-1][l][Q_W-2:0], n_bit[l]};
                end
            end
        end
    end

    assign o_valid = r_v[Q_W];
    assign o_quo   = r_q[Q_W];
    assign o_ovf   = r_ovf[Q_W];
    assign o_tag   = r_tag[Q_W];

endmodule

`default_nettype wire

// ===== hw/rtl/bsp_front.sv =====
// Front end: world offset, products, camera-space numerators and determinant.
// Four stages; depends on bsp_pkg.
`default_nettype none

module bsp_front
    import bsp_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cfg                          i_cfg,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [POS_W-1:0]              i_sprite_x,
    input  logic [POS_W-1:0]              i_sprite_y,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [1:0][NUM1_W-1:0]        o_num,
    output logic [DEN_W-1:0]              o_den,
    output t_div1_tag                     o_tag
);

    logic [3:0] r_v;
    logic [4:0] en;

    logic signed [24:0] r_dx, r_dy;
    logic signed [40:0] r_pa, r_pb, r_pc, r_pd;
    logic signed [31:0] r_da, r_db;
    logic signed [41:0] r_nx, r_ny;
    logic signed [32:0] r_det;
    logic [1:0][NUM1_W-1:0] r_num;
    logic [DEN_W-1:0]       r_den;
    t_div1_tag              r_tag;

    logic [40:0] n_nx_mag, n_ny_mag;
    logic [31:0] n_det_mag;
    logic        n_det_ok;

    assign en[4] = i_ready;
    genvar k;
    for (k = 0; k < 4; k++) begin : g_en
        assign en[k] = !r_v[k] || en[k+1];
    end
    assign o_ready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_valid;
            if (en[1]) r_v[1] <= r_v[0];
            if (en[2]) r_v[2] <= r_v[1];
            if (en[3]) r_v[3] <= r_v[2];
        end
    end

    always_comb begin
        logic signed [41:0] v_nx, v_ny;
        logic signed [32:0] v_det;
        v_nx      = r_nx[41] ? (42'sd0 - r_nx) : r_nx;
        v_ny      = r_ny[41] ? (42'sd0 - r_ny) : r_ny;
        v_det     = r_det[32] ? (33'sd0 - r_det) : r_det;
        n_nx_mag  = v_nx[40:0];
        n_ny_mag  = v_ny[40:0];
        n_det_mag = v_det[31:0];
        n_det_ok  = (r_det != 33'sd0) && (n_det_mag >= 32'(DET_EPS));
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_dx <= $signed({1'b0, i_sprite_x}) - $signed({1'b0, i_cfg.viewer_x});
            r_dy <= $signed({1'b0, i_sprite_y}) - $signed({1'b0, i_cfg.viewer_y});
        end
        if (en[1]) begin
            r_pa <= 41'(i_cfg.dir_y) * 41'(r_dx);
            r_pb <= 41'(i_cfg.dir_x) * 41'(r_dy);
            r_pc <= 41'(i_cfg.plane_x) * 41'(r_dy);
            r_pd <= 41'(i_cfg.plane_y) * 41'(r_dx);
            r_da <= 32'(i_cfg.plane_x) * 32'(i_cfg.dir_y);
            r_db <= 32'(i_cfg.dir_x) * 32'(i_cfg.plane_y);
        end
        if (en[2]) begin
            r_nx  <= 42'(r_pa) - 42'(r_pb);
            r_ny  <= 42'(r_pc) - 42'(r_pd);
            r_det <= 33'(r_da) - 33'(r_db);
        end
        if (en[3]) begin
            r_num[0]     <= {n_nx_mag, {FRAC_SH{1'b0}}};
            r_num[1]     <= {n_ny_mag, {FRAC_SH{1'b0}}};
            r_den        <= n_det_mag;
            r_tag.sx     <= r_nx[41] ^ r_det[32];
            r_tag.sdp    <= r_ny[41] ^ r_det[32];
            r_tag.det_ok <= n_det_ok;
        end
    end

    assign o_valid = r_v[3];
    assign o_num   = r_num;
    assign o_den   = r_den;
    assign o_tag   = r_tag;

endmodule

`default_nettype wire

// ===== hw/rtl/bsp_mid.sv =====
// Middle: signs and saturation of cam_x and depth, column and height numerators.
// Four stages; depends on bsp_pkg.
`default_nettype none

module bsp_mid
    import bsp_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cfg                          i_cfg,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0][Q1_W-1:0]          i_quo,
    input  logic [1:0]                    i_ovf,
    input  t_div1_tag                     i_tag,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [1:0][NUM2_W-1:0]        o_num,
    output logic [DEN_W-1:0]              o_den,
    output t_mid_tag                      o_tag
);

    logic [3:0] r_v;
    logic [4:0] en;

    logic signed [31:0] r1_cx, r2_cx, r3_cx;
    logic        [30:0] r1_dp, r2_dp, r3_dp;
    logic               r1_vis, r2_vis, r3_vis;
    logic signed [32:0] r2_s;
    logic               r3_neg;
    logic        [31:0] r3_mag;
    logic [1:0][NUM2_W-1:0] r_num;
    logic [DEN_W-1:0]       r_den;
    t_mid_tag               r_tag;

    logic signed [31:0] n_cx;
    logic        [30:0] n_dp;
    logic               n_vis;
    logic        [31:0] n_mag;

    assign en[4] = i_ready;
    genvar k;
    for (k = 0; k < 4; k++) begin : g_en
        assign en[k] = !r_v[k] || en[k+1];
    end
    assign o_ready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_valid;
            if (en[1]) r_v[1] <= r_v[0];
            if (en[2]) r_v[2] <= r_v[1];
            if (en[3]) r_v[3] <= r_v[2];
        end
    end

    always_comb begin
        logic v_big;
        logic signed [32:0] v_abs;
        v_big = i_ovf[0] || i_quo[0][31];
        if (!i_tag.sx) begin
            n_cx = v_big ? 32'sh7FFF_FFFF : $signed(i_quo[0]);
        end else begin
            n_cx = v_big ? 32'sh8000_0000 : $signed(32'd0 - i_quo[0]);
        end
        n_dp  = (i_ovf[1] || i_quo[1][31]) ? 31'h7FFF_FFFF : i_quo[1][30:0];
        n_vis = i_tag.det_ok && !i_tag.sdp && (i_ovf[1] || (i_quo[1] != '0));
        v_abs = r2_s[32] ? (33'sd0 - r2_s) : r2_s;
        n_mag = v_abs[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r1_cx  <= n_cx;
            r1_dp  <= n_dp;
            r1_vis <= n_vis;
        end
        if (en[1]) begin
            r2_s   <= 33'(r1_cx) + $signed({2'b0, r1_dp});
            r2_cx  <= r1_cx;
            r2_dp  <= r1_dp;
            r2_vis <= r1_vis;
        end
        if (en[2]) begin
            r3_neg <= r2_s[32];
            r3_mag <= n_mag;
            r3_cx  <= r2_cx;
            r3_dp  <= r2_dp;
            r3_vis <= r2_vis;
        end
        if (en[3]) begin
            r_num[0]      <= NUM2_W'(i_cfg.w) * NUM2_W'(r3_mag);
            r_num[1]      <= NUM2_W'({i_cfg.h, 13'b0});
            r_den         <= {r3_dp, 1'b0};
            r_tag.cx      <= r3_cx;
            r_tag.dp      <= r3_dp;
            r_tag.vis     <= r3_vis;
            r_tag.col_neg <= r3_neg;
        end
    end

    assign o_valid = r_v[3];
    assign o_num   = r_num;
    assign o_den   = r_den;
    assign o_tag   = r_tag;

endmodule

`default_nettype wire

// ===== hw/rtl/bsp_back.sv =====
// Back end: column and box size saturation, clipped edges, output register.
// Three stages; depends on bsp_pkg.
`default_nettype none

module bsp_back
    import bsp_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cfg                          i_cfg,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0][Q2_W-1:0]          i_quo,
    input  logic [1:0]                    i_ovf,
    input  t_mid_tag                      i_tag,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_visible,
    output logic signed [31:0]            o_cam_x,
    output logic [30:0]                   o_depth,
    output logic signed [15:0]            o_screen_col,
    output logic [12:0]                   o_box_height,
    output logic [12:0]                   o_box_width,
    output logic [14:0]                   o_left_col,
    output logic signed [15:0]            o_right_col,
    output logic [11:0]                   o_top_row,
    output logic [11:0]                   o_bottom_row
);

    logic [2:0] r_v;
    logic [3:0] en;

    t_mid_tag           r1_tag, r2_tag;
    logic signed [15:0] r1_col, r2_col;
    logic [12:0]        r1_bh, r2_bh, r2_bw;
    logic [11:0]        r2_top, r2_bot;

    logic               r3_vis;
    logic signed [31:0] r3_cx;
    logic [30:0]        r3_dp;
    logic signed [15:0] r3_col, r3_rgt;
    logic [12:0]        r3_bh, r3_bw;
    logic [14:0]        r3_lft;
    logic [11:0]        r3_top, r3_bot;

    logic signed [15:0] n_col;
    logic [12:0]        n_bh, n_bw;
    logic [11:0]        n_top, n_bot;
    logic [14:0]        n_lft;
    logic signed [15:0] n_rgt;

    assign en[3] = i_ready;
    genvar k;
    for (k = 0; k < 3; k++) begin : g_en
        assign en[k] = !r_v[k] || en[k+1];
    end
    assign o_ready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_valid;
            if (en[1]) r_v[1] <= r_v[0];
            if (en[2]) r_v[2] <= r_v[1];
        end
    end

    always_comb begin
        logic [12:0]        v_bh;
        logic [12:0]        v_sum;
        logic signed [16:0] v_half, v_l, v_r, v_w;
        // stage 1
        if (i_tag.col_neg) begin
            n_col = (i_ovf[0] || i_quo[0][15]) ? 16'sh8000 : $signed(16'd0 - i_quo[0]);
        end else begin
            n_col = (i_ovf[0] || (i_quo[0] >= 16'h7FFF)) ? 16'sh7FFF : $signed(i_quo[0]);
        end
        v_bh = (i_ovf[1] || (i_quo[1] >= 16'(i_cfg.h))) ? i_cfg.h : i_quo[1][12:0];
        n_bh = (v_bh == '0) ? 13'd1 : v_bh;
        // stage 2
        n_bw  = (r1_bh < i_cfg.w) ? r1_bh : i_cfg.w;
        n_top = 12'(i_cfg.h[12:1]) - 12'(r1_bh[12:1]);
        v_sum = 13'(i_cfg.h[12:1]) + 13'(r1_bh[12:1]);
        n_bot = (v_sum >= i_cfg.h) ? 12'(i_cfg.h - 13'd1) : v_sum[11:0];
        // stage 3
        v_half = $signed({5'b0, r2_bw[12:1]});
        v_w    = $signed({4'b0, i_cfg.w});
        v_l    = 17'(r2_col) - v_half;
        v_r    = 17'(r2_col) + v_half;
        n_lft  = v_l[16] ? 15'd0 : v_l[14:0];
        n_rgt  = (v_r >= v_w) ? $signed(16'(i_cfg.w - 13'd1)) : v_r[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r1_tag <= i_tag;
            r1_col <= n_col;
            r1_bh  <= n_bh;
        end
        if (en[1]) begin
            r2_tag <= r1_tag;
            r2_col <= r1_col;
            r2_bh  <= r1_bh;
            r2_bw  <= n_bw;
            r2_top <= n_top;
            r2_bot <= n_bot;
        end
        if (en[2]) begin
            // hidden sprites report all zero
            r3_vis <= r2_tag.vis;
            r3_cx  <= r2_tag.vis ? r2_tag.cx : '0;
            r3_dp  <= r2_tag.vis ? r2_tag.dp : '0;
            r3_col <= r2_tag.vis ? r2_col : '0;
            r3_bh  <= r2_tag.vis ? r2_bh : '0;
            r3_bw  <= r2_tag.vis ? r2_bw : '0;
            r3_lft <= r2_tag.vis ? n_lft : '0;
            r3_rgt <= r2_tag.vis ? n_rgt : '0;
            r3_top <= r2_tag.vis ? r2_top : '0;
            r3_bot <= r2_tag.vis ? r2_bot : '0;
        end
    end

    assign o_valid      = r_v[2];
    assign o_visible    = r3_vis;
    assign o_cam_x      = r3_cx;
    assign o_depth      = r3_dp;
    assign o_screen_col = r3_col;
    assign o_box_height = r3_bh;
    assign o_box_width  = r3_bw;
    assign o_left_col   = r3_lft;
    assign o_right_col  = r3_rgt;
    assign o_top_row    = r3_top;
    assign o_bottom_row = r3_bot;

endmodule

`default_nettype wire

// ===== hw/rtl/billboard_sprite_projection.sv =====
// Billboard sprite projection top level: configuration registers and pipeline.
// Depends on bsp_pkg, bsp_front, bsp_div, bsp_mid, bsp_back.
//
//  Channel | Signals                                   | Handshake
//  --------+-------------------------------------------+------------------
//  cfg     | i_cfg_wr_en, i_cfg_addr, i_cfg_wdata      | write on wr_en
//  in      | i_sprite_x, i_sprite_y                    | i_valid / o_ready
//  out     | o_visible .. o_bottom_row                 | o_valid / i_ready
//
// One word per cycle sustained while i_ready is high; the pipeline is the two
// pipelined dividers (33 and 17 stages) plus 11 arithmetic stages.
// Synchronous active-low reset clears all stage valids and loads the config registers with defaults.
// Per-stage enables close bubbles, so words are taken while the output waits until every stage is full.
`default_nettype none

module billboard_sprite_projection
    import bsp_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [2:0]                 i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]      i_cfg_wdata,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [23:0]                i_sprite_x,
    input  logic [23:0]                i_sprite_y,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic                       o_visible,
    output logic signed [31:0]         o_cam_x,
    output logic [30:0]                o_depth,
    output logic signed [15:0]         o_screen_col,
    output logic [12:0]                o_box_height,
    output logic [12:0]                o_box_width,
    output logic [14:0]                o_left_col,
    output logic signed [15:0]         o_right_col,
    output logic [11:0]                o_top_row,
    output logic [11:0]                o_bottom_row
);

    logic [POS_W-1:0]        r_viewer_x, r_viewer_y;
    logic signed [DIR_W-1:0] r_dir_x, r_dir_y, r_plane_x, r_plane_y;
    logic [PIX_W-1:0]        r_scr_w, r_scr_h;
    t_cfg                    cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_viewer_x <= '0;
            r_viewer_y <= '0;
            r_dir_x    <= 16'sd16384;
            r_dir_y    <= '0;
            r_plane_x  <= '0;
            r_plane_y  <= 16'sd10813;
            r_scr_w    <= 13'd640;
            r_scr_h    <= 13'd480;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_reg'(i_cfg_addr))
                REG_VIEWER_X: r_viewer_x <= i_cfg_wdata[POS_W-1:0];
                REG_VIEWER_Y: r_viewer_y <= i_cfg_wdata[POS_W-1:0];
                REG_DIR_X:    r_dir_x    <= $signed(i_cfg_wdata[DIR_W-1:0]);
                REG_DIR_Y:    r_dir_y    <= $signed(i_cfg_wdata[DIR_W-1:0]);
                REG_PLANE_X:  r_plane_x  <= $signed(i_cfg_wdata[DIR_W-1:0]);
                REG_PLANE_Y:  r_plane_y  <= $signed(i_cfg_wdata[DIR_W-1:0]);
                REG_SCR_W:    r_scr_w    <= i_cfg_wdata[PIX_W-1:0];
                REG_SCR_H:    r_scr_h    <= i_cfg_wdata[PIX_W-1:0];
                default:      r_scr_h    <= r_scr_h;
            endcase
        end
    end

    // window size held to 1..4096
    always_comb begin
        cfg.viewer_x = r_viewer_x;
        cfg.viewer_y = r_viewer_y;
        cfg.dir_x    = r_dir_x;
        cfg.dir_y    = r_dir_y;
        cfg.plane_x  = r_plane_x;
        cfg.plane_y  = r_plane_y;
        cfg.w = (r_scr_w == '0) ? 13'd1 : ((r_scr_w > PIX_MAX) ? PIX_MAX : r_scr_w);
        cfg.h = (r_scr_h == '0) ? 13'd1 : ((r_scr_h > PIX_MAX) ? PIX_MAX : r_scr_h);
    end

    logic                    f_valid, f_ready;
    logic [1:0][NUM1_W-1:0]  f_num;
    logic [DEN_W-1:0]        f_den;
    t_div1_tag               f_tag;

    logic                    d1_valid, d1_ready;
    logic [1:0][Q1_W-1:0]    d1_quo;
    logic [1:0]              d1_ovf;
    t_div1_tag               d1_tag;

    logic                    m_valid, m_ready;
    logic [1:0][NUM2_W-1:0]  m_num;
    logic [DEN_W-1:0]        m_den;
    t_mid_tag                m_tag;

    logic                    d2_valid, d2_ready;
    logic [1:0][Q2_W-1:0]    d2_quo;
    logic [1:0]              d2_ovf;
    t_mid_tag                d2_tag;

    bsp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_sprite_x (i_sprite_x),
        .i_sprite_y (i_sprite_y),
        .o_valid    (f_valid),
        .i_ready    (f_ready),
        .o_num      (f_num),
        .o_den      (f_den),
        .o_tag      (f_tag)
    );

    bsp_div #(
        .LANES (2),
        .NUM_W (NUM1_W),
        .DEN_W (DEN_W),
        .Q_W   (Q1_W),
        .TAG_W ($bits(t_div1_tag))
    ) u_div_cam (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_num   (f_num),
        .i_den   (f_den),
        .i_tag   (f_tag),
        .o_valid (d1_valid),
        .i_ready (d1_ready),
        .o_quo   (d1_quo),
        .o_ovf   (d1_ovf),
        .o_tag   (d1_tag)
    );

    bsp_mid u_mid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (d1_valid),
        .o_ready (d1_ready),
        .i_quo   (d1_quo),
        .i_ovf   (d1_ovf),
        .i_tag   (d1_tag),
        .o_valid (m_valid),
        .i_ready (m_ready),
        .o_num   (m_num),
        .o_den   (m_den),
        .o_tag   (m_tag)
    );

    bsp_div #(
        .LANES (2),
        .NUM_W (NUM2_W),
        .DEN_W (DEN_W),
        .Q_W   (Q2_W),
        .TAG_W ($bits(t_mid_tag))
    ) u_div_scr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (m_valid),
        .o_ready (m_ready),
        .i_num   (m_num),
        .i_den   (m_den),
        .i_tag   (m_tag),
        .o_valid (d2_valid),
        .i_ready (d2_ready),
        .o_quo   (d2_quo),
        .o_ovf   (d2_ovf),
        .o_tag   (d2_tag)
    );

    bsp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_valid      (d2_valid),
        .o_ready      (d2_ready),
        .i_quo        (d2_quo),
        .i_ovf        (d2_ovf),
        .i_tag        (d2_tag),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_visible    (o_visible),
        .o_cam_x      (o_cam_x),
        .o_depth      (o_depth),
        .o_screen_col (o_screen_col),
        .o_box_height (o_box_height),
        .o_box_width  (o_box_width),
        .o_left_col   (o_left_col),
        .o_right_col  (o_right_col),
        .o_top_row    (o_top_row),
        .o_bottom_row (o_bottom_row)
    );

endmodule

`default_nettype wire
